>>> rtl/vlt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the voxel line walker.
package vlt_pkg;

    // Field widths
    localparam int COORD_W  = 12;
    localparam int DLT_W    = COORD_W + 1;
    localparam int IDX_W    = 6;
    localparam int REASON_W = 2;
    localparam int IN_W     = 6 * COORD_W;
    localparam int OUT_W    = 48;

    // Parameter defaults
    localparam int DEF_MAX_CELLS  = 64;
    localparam int DEF_MAP_SIDE   = 512;
    localparam int DEF_MAP_HEIGHT = 64;
    localparam int DEF_STEP_ONE   = 1024;

    // Increment used for an axis whose delta is zero
    localparam int HUGE_STEP = 'h3fffffff / 512;

    // Reason carried on the final cell of a line
    typedef enum logic [REASON_W-1:0] {
        STOP_END    = 2'd0,
        STOP_LIMIT  = 2'd1,
        STOP_BOUNDS = 2'd2
    } stop_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic acc_init;
        logic walk;
    } vlt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic cell_last;
    } vlt_stat_t;

endpackage

>>> rtl/vlt_div.sv
// Restoring unsigned divider that resolves two quotient bits per cycle.
module vlt_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DEN_W:0]   trial1, trial2;
    logic             ge1, ge2;
    logic [DEN_W-1:0] rem1;
    logic [NUM_W-1:0] q1;

    // Two dependent shift-compare-subtract steps
    always_comb
    begin
        trial1   = {rem_reg, quo_reg[NUM_W-1]};
        ge1      = (trial1 >= {1'b0, den_reg});
        rem1     = ge1 ? DEN_W'(trial1 - {1'b0, den_reg}) : trial1[DEN_W-1:0];
        q1       = {quo_reg[NUM_W-2:0], ge1};
        trial2   = {rem1, q1[NUM_W-1]};
        ge2      = (trial2 >= {1'b0, den_reg});
        rem_next = ge2 ? DEN_W'(trial2 - {1'b0, den_reg}) : trial2[DEN_W-1:0];
        quo_next = {q1[NUM_W-2:0], ge2};
    end

    // Iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = quo_reg;
    assign done = (cnt_reg == '0);

endmodule

>>> rtl/vlt_datapath.sv
// Datapath: line set-up, increment division, accumulator walk and output register.
module vlt_datapath #(
    parameter int MAX_CELLS  = vlt_pkg::DEF_MAX_CELLS,
    parameter int MAP_SIDE   = vlt_pkg::DEF_MAP_SIDE,
    parameter int MAP_HEIGHT = vlt_pkg::DEF_MAP_HEIGHT,
    parameter int STEP_ONE   = vlt_pkg::DEF_STEP_ONE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vlt_pkg::vlt_cmd_t              cmd,
    output vlt_pkg::vlt_stat_t             stat,
    input  logic [vlt_pkg::IN_W-1:0]       s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vlt_pkg::OUT_W-1:0]      m_tdata,
    output logic                           m_tlast,
    output logic [vlt_pkg::REASON_W-1:0]   m_tuser
);

    import vlt_pkg::*;

    localparam int NUM_W  = $clog2(((1 << COORD_W) - 1) * STEP_ONE + 1);
    localparam int DIV_W  = NUM_W + (NUM_W % 2);
    localparam int HUGE_W = $clog2(HUGE_STEP + 1);
    localparam int INC_W  = (DIV_W > HUGE_W) ? DIV_W : HUGE_W;
    localparam int N_W    = $clog2(MAX_CELLS);
    localparam int ACC_W  = INC_W + N_W + 1;
    localparam int PAD_W  = OUT_W - 3 * COORD_W - IDX_W;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // Walk state
    logic [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [COORD_W-1:0] ex_reg, ey_reg, ez_reg;
    logic               negx_reg, negy_reg, negz_reg;
    logic [COORD_W-1:0] adx_reg, ady_reg, adz_reg;
    logic [INC_W-1:0]   ix_reg, iy_reg, iz_reg;
    logic [ACC_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [N_W-1:0]     n_reg;

    // Output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [IDX_W-1:0]   oidx_reg;
    logic               olast_reg;
    logic [REASON_W-1:0] oreason_reg;

    // Input unpacking and deltas
    logic [COORD_W-1:0] in_sx, in_sy, in_sz, in_ex, in_ey, in_ez;
    logic [DLT_W-1:0]   dx, dy, dz;

    always_comb
    begin
        in_sx = s_tdata[0*COORD_W +: COORD_W];
        in_sy = s_tdata[1*COORD_W +: COORD_W];
        in_sz = s_tdata[2*COORD_W +: COORD_W];
        in_ex = s_tdata[3*COORD_W +: COORD_W];
        in_ey = s_tdata[4*COORD_W +: COORD_W];
        in_ez = s_tdata[5*COORD_W +: COORD_W];
        dx = {in_ex[COORD_W-1], in_ex} - {in_sx[COORD_W-1], in_sx};
        dy = {in_ey[COORD_W-1], in_ey} - {in_sy[COORD_W-1], in_sy};
        dz = {in_ez[COORD_W-1], in_ez} - {in_sz[COORD_W-1], in_sz};
    end

    // Major axis and divider operands; x wins over y over z on equal deltas
    axis_t              major;
    logic [COORD_W-1:0] maj_abs, den_a, den_b;
    logic [DIV_W-1:0]   num;

    always_comb
    begin
        if (adx_reg >= ady_reg && adx_reg >= adz_reg)
        begin
            major = AXIS_X;
        end
        else if (ady_reg >= adz_reg)
        begin
            major = AXIS_Y;
        end
        else
        begin
            major = AXIS_Z;
        end
        unique case (major)
            AXIS_Y:
            begin
                maj_abs = ady_reg;
                den_a   = adx_reg;
                den_b   = adz_reg;
            end
            AXIS_Z:
            begin
                maj_abs = adz_reg;
                den_a   = adx_reg;
                den_b   = ady_reg;
            end
            default:
            begin
                maj_abs = adx_reg;
                den_a   = ady_reg;
                den_b   = adz_reg;
            end
        endcase
        num = DIV_W'(maj_abs) * DIV_W'(STEP_ONE);
    end

    // One divider per minor axis
    logic [DIV_W-1:0] quot_a, quot_b;
    logic             done_a, done_b;

    vlt_div #(
        .NUM_W (DIV_W),
        .DEN_W (COORD_W)
    ) u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den_a),
        .quot  (quot_a),
        .done  (done_a)
    );

    vlt_div #(
        .NUM_W (DIV_W),
        .DEN_W (COORD_W)
    ) u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den_b),
        .quot  (quot_b),
        .done  (done_b)
    );

    // Increments and starting accumulators
    logic [INC_W-1:0] inc_a, inc_b, inc_x, inc_y, inc_z;
    logic [ACC_W-1:0] acc_x0, acc_y0, acc_z0;

    always_comb
    begin
        inc_a = (den_a == '0) ? INC_W'(HUGE_STEP) : INC_W'(quot_a);
        inc_b = (den_b == '0) ? INC_W'(HUGE_STEP) : INC_W'(quot_b);
        unique case (major)
            AXIS_Y:
            begin
                inc_x = inc_a;
                inc_y = INC_W'(STEP_ONE);
                inc_z = inc_b;
            end
            AXIS_Z:
            begin
                inc_x = inc_a;
                inc_y = inc_b;
                inc_z = INC_W'(STEP_ONE);
            end
            default:
            begin
                inc_x = INC_W'(STEP_ONE);
                inc_y = inc_a;
                inc_z = inc_b;
            end
        endcase
        acc_x0 = negx_reg ? ACC_W'(inc_x >> 1) : ACC_W'(inc_x - (inc_x >> 1));
        acc_y0 = negy_reg ? ACC_W'(inc_y >> 1) : ACC_W'(inc_y - (inc_y >> 1));
        acc_z0 = negz_reg ? ACC_W'(inc_z >> 1) : ACC_W'(inc_z - (inc_z >> 1));
    end

    // Step choice, bounds test and stop decision for the current cell
    logic               move_x, move_z, at_limit, at_end, in_map, last_now;
    logic [COORD_W-1:0] cur, lim;
    logic               cur_neg;
    logic [DLT_W-1:0]   nxt;
    stop_t              reason_now;

    always_comb
    begin
        move_z  = (az_reg <= ax_reg) && (az_reg <= ay_reg);
        move_x  = !move_z && (ax_reg < ay_reg);
        cur     = move_z ? cz_reg : (move_x ? cx_reg : cy_reg);
        cur_neg = move_z ? negz_reg : (move_x ? negx_reg : negy_reg);
        lim     = move_z ? COORD_W'(MAP_HEIGHT - 1) : COORD_W'(MAP_SIDE - 1);
        nxt     = {cur[COORD_W-1], cur} + (cur_neg ? {DLT_W{1'b1}} : DLT_W'(1));
        in_map  = !nxt[DLT_W-1] && (nxt[COORD_W-1:0] <= lim);
        at_limit = (n_reg == N_W'(MAX_CELLS - 1));
        at_end   = (cx_reg == ex_reg) && (cy_reg == ey_reg) && (cz_reg == ez_reg);
        last_now = at_limit || at_end || !in_map;
        if (at_limit)
        begin
            reason_now = STOP_LIMIT;
        end
        else if (at_end || in_map)
        begin
            reason_now = STOP_END;
        end
        else
        begin
            reason_now = STOP_BOUNDS;
        end
    end

    // Control registers: cell count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg <= '0;
            end
            else if (cmd.walk && !last_now)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (cmd.walk)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= in_sx;
            cy_reg   <= in_sy;
            cz_reg   <= in_sz;
            ex_reg   <= in_ex;
            ey_reg   <= in_ey;
            ez_reg   <= in_ez;
            negx_reg <= dx[DLT_W-1];
            negy_reg <= dy[DLT_W-1];
            negz_reg <= dz[DLT_W-1];
            adx_reg  <= dx[DLT_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
            ady_reg  <= dy[DLT_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
            adz_reg  <= dz[DLT_W-1] ? COORD_W'(-dz) : COORD_W'(dz);
        end
        if (cmd.acc_init)
        begin
            ix_reg <= inc_x;
            iy_reg <= inc_y;
            iz_reg <= inc_z;
            ax_reg <= acc_x0;
            ay_reg <= acc_y0;
            az_reg <= acc_z0;
        end
        if (cmd.walk)
        begin
            ox_reg      <= cx_reg;
            oy_reg      <= cy_reg;
            oz_reg      <= cz_reg;
            oidx_reg    <= IDX_W'(n_reg);
            olast_reg   <= last_now;
            oreason_reg <= last_now ? reason_now : STOP_END;
            if (!last_now)
            begin
                if (move_z)
                begin
                    cz_reg <= nxt[COORD_W-1:0];
                    az_reg <= az_reg + ACC_W'(iz_reg);
                end
                else if (move_x)
                begin
                    cx_reg <= nxt[COORD_W-1:0];
                    ax_reg <= ax_reg + ACC_W'(ix_reg);
                end
                else
                begin
                    cy_reg <= nxt[COORD_W-1:0];
                    ay_reg <= ay_reg + ACC_W'(iy_reg);
                end
            end
        end
    end

    // Status and output port
    always_comb
    begin
        stat.div_done  = done_a && done_b;
        stat.out_free  = !out_valid_reg || m_tready;
        stat.cell_last = last_now;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, oidx_reg, oz_reg, oy_reg, ox_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oreason_reg;

endmodule

>>> rtl/vlt_ctrl.sv
// Controller: sequences set-up, division, accumulator load and the cell walk.
module vlt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output vlt_pkg::vlt_cmd_t  cmd,
    input  vlt_pkg::vlt_stat_t stat
);

    import vlt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_INIT,
        ST_WALK
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.acc_init  = 1'b0;
        cmd.walk      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.acc_init = 1'b1;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.walk = 1'b1;
                    if (stat.cell_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> rtl/voxel_line_traversal_unit.sv
// Top level of the voxel line walker: controller, datapath and checks.
// After the input transfer the controller runs set-up, the increment divide (on an even
// numerator width, 22 bits at STEP_ONE = 1024) and the accumulator load before the first cell.
// One line at a time: a new line is taken only once the walk has issued its last cell, and
// the walk waits while the output register holds a cell that is not taken.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and empties the output.
module voxel_line_traversal_unit #(
    parameter int MAX_CELLS  = vlt_pkg::DEF_MAX_CELLS,
    parameter int MAP_SIDE   = vlt_pkg::DEF_MAP_SIDE,
    parameter int MAP_HEIGHT = vlt_pkg::DEF_MAP_HEIGHT,
    parameter int STEP_ONE   = vlt_pkg::DEF_STEP_ONE
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (12 bits each)
    input  logic [vlt_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cell_x, cell_y, cell_z (12 bits each), step_index (6 bits), 6 zero bits
    output logic [vlt_pkg::OUT_W-1:0]    m_tdata,
    output logic                         m_tlast,
    // stop_reason (2 bits)
    output logic [vlt_pkg::REASON_W-1:0] m_tuser
);

    import vlt_pkg::*;

    vlt_cmd_t  cmd;
    vlt_stat_t stat;

    vlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vlt_datapath #(
        .MAX_CELLS  (MAX_CELLS),
        .MAP_SIDE   (MAP_SIDE),
        .MAP_HEIGHT (MAP_HEIGHT),
        .STEP_ONE   (STEP_ONE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A new line is not taken right after one was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // While a cell that is not the last one waits, the walk is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("block idle before the final cell of a line");

    // A stop reason other than end-reached only appears on the final cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == STOP_END))
        else $error("stop reason on a cell that is not the last");

endmodule
